// ===== rtl/u2u8_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 converter package
// Shared constants, the conversion job record and the encoding helpers.
// ----------------------------------------------------------------------------
package u2u8_pkg;

  localparam int UnitWidth   = 16;
  localparam int ByteWidth   = 8;
  localparam int CountWidth  = 16;
  localparam int MaxBytes    = 4;
  localparam int NbWidth     = 3;
  localparam int QueueDepthDefault = 4;

  localparam logic [15:0] BufferBytesReset = 16'd256;

  localparam logic [15:0] SurrFirst    = 16'hD800;
  localparam logic [15:0] HighLast     = 16'hDBFF;
  localparam logic [15:0] LowFirst     = 16'hDC00;
  localparam logic [15:0] LowLast      = 16'hDFFF;
  localparam logic [15:0] SurrMask     = 16'hF800;
  localparam logic [20:0] SuppBase     = 21'h10000;
  localparam logic [20:0] TwoByteFirst = 21'h00080;
  localparam logic [20:0] ThreeByteFirst = 21'h00800;
  localparam logic [20:0] FourByteFirst  = 21'h10000;

  localparam logic [1:0] ContTag  = 2'b10;
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [4:0] Lead4Tag = 5'b11110;

  // One converted item: data bytes in send order, optional terminator.
  typedef struct packed {
    logic [MaxBytes-1:0][ByteWidth-1:0] data;
    logic [NbWidth-1:0]                 nbytes;
    logic                               has_nul;
    logic [CountWidth-1:0]              count;
  } u2u8_job_t;

  // Push side of the job queue.
  typedef struct packed {
    logic      valid;
    u2u8_job_t job;
  } u2u8_push_t;

  // Pop side of the job queue, as seen by the consumer.
  typedef struct packed {
    logic      valid;
    u2u8_job_t job;
  } u2u8_head_t;

  // Number of UTF-8 bytes for a scalar value.
  function automatic logic [NbWidth-1:0] utf8_width(input logic [20:0] v);
    logic [NbWidth-1:0] w;
    if (v < TwoByteFirst) begin
      w = 3'd1;
    end else if (v < ThreeByteFirst) begin
      w = 3'd2;
    end else if (v < FourByteFirst) begin
      w = 3'd3;
    end else begin
      w = 3'd4;
    end
    return w;
  endfunction

  // UTF-8 bytes of a scalar value, lead byte in slot 0.
  function automatic logic [MaxBytes-1:0][ByteWidth-1:0] utf8_bytes(input logic [20:0] v);
    logic [MaxBytes-1:0][ByteWidth-1:0] b;
    b = '0;
    if (v < TwoByteFirst) begin
      b[0] = v[7:0];
    end else if (v < ThreeByteFirst) begin
      b[0] = {Lead2Tag, v[10:6]};
      b[1] = {ContTag, v[5:0]};
    end else if (v < FourByteFirst) begin
      b[0] = {Lead3Tag, v[15:12]};
      b[1] = {ContTag, v[11:6]};
      b[2] = {ContTag, v[5:0]};
    end else begin
      b[0] = {Lead4Tag, v[20:18]};
      b[1] = {ContTag, v[17:12]};
      b[2] = {ContTag, v[11:6]};
      b[3] = {ContTag, v[5:0]};
    end
    return b;
  endfunction

endpackage

// ===== rtl/u2u8_ifs.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 converter channel interfaces
// Valid/ready channels for code units, result bytes and the capacity write.
// ----------------------------------------------------------------------------
interface u2u8_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  modport source (output valid, output code_unit, input ready);
  modport sink   (input valid, input code_unit, output ready);
endinterface

interface u2u8_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        is_last;
  logic [15:0] bytes_written;
  modport source (output valid, output out_byte, output is_last, output bytes_written,
                  input ready);
  modport sink   (input valid, input out_byte, input is_last, input bytes_written,
                  output ready);
endinterface

interface u2u8_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] buffer_bytes;
  modport source (output valid, output buffer_bytes, input ready);
  modport sink   (input valid, input buffer_bytes, output ready);
endinterface

// ===== rtl/u2u8_front.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 converter front end
// Accepts code units, tracks surrogates and capacity, and builds jobs.
// ----------------------------------------------------------------------------
module u2u8_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  unit_valid,
  input  logic [15:0]           code_unit,
  output logic                  unit_ready,
  input  logic                  cfg_valid,
  input  logic [15:0]           cfg_buffer_bytes,
  input  logic                  queue_full,
  output u2u8_pkg::u2u8_push_t  push
);

  logic        high_pending_r, high_pending_nxt;
  logic [9:0]  high_bits_r, high_bits_nxt;
  logic [15:0] space_left_r, space_left_nxt;
  logic [15:0] written_r, written_nxt;
  logic        closed_r, closed_nxt;
  logic [15:0] buffer_bytes_r;
  logic [15:0] full_space;
  logic        accept;

  assign unit_ready = !queue_full;
  assign accept     = unit_valid && unit_ready;
  assign full_space = (buffer_bytes_r == 16'd0) ? 16'd0 : buffer_bytes_r - 16'd1;

  always_comb begin
    logic [20:0]                 value;
    logic                        have_char;
    logic [u2u8_pkg::NbWidth-1:0] width;
    logic [15:0]                 space_after;
    logic [15:0]                 written_after;

    high_pending_nxt = high_pending_r;
    high_bits_nxt    = high_bits_r;
    space_left_nxt   = space_left_r;
    written_nxt      = written_r;
    closed_nxt       = closed_r;
    push             = '0;
    value            = '0;
    have_char        = 1'b0;
    width            = '0;
    space_after      = '0;
    written_after    = '0;

    if (accept) begin
      if (code_unit == 16'd0) begin
        // End of string: terminator unless already closed, then rearm.
        if (!closed_r) begin
          push.valid       = 1'b1;
          push.job.has_nul = 1'b1;
          push.job.count   = written_r;
        end
        high_pending_nxt = 1'b0;
        high_bits_nxt    = '0;
        space_left_nxt   = full_space;
        written_nxt      = '0;
        closed_nxt       = 1'b0;
      end else if (!closed_r) begin
        if (high_pending_r) begin
          high_pending_nxt = 1'b0;
          high_bits_nxt    = '0;
          if (code_unit >= u2u8_pkg::LowFirst && code_unit <= u2u8_pkg::LowLast) begin
            value     = {1'b0, high_bits_r, code_unit[9:0]} + u2u8_pkg::SuppBase;
            have_char = 1'b1;
          end
        end else if (space_left_r == 16'd0) begin
          push.valid       = 1'b1;
          push.job.has_nul = 1'b1;
          push.job.count   = written_r;
          closed_nxt       = 1'b1;
        end else if ((code_unit & u2u8_pkg::SurrMask) == u2u8_pkg::SurrFirst) begin
          if (code_unit <= u2u8_pkg::HighLast) begin
            high_pending_nxt = 1'b1;
            high_bits_nxt    = code_unit[9:0];
          end
        end else begin
          value     = {5'd0, code_unit};
          have_char = 1'b1;
        end

        if (have_char) begin
          width = u2u8_pkg::utf8_width(value);
          if (space_left_r < {13'd0, width}) begin
            // Character does not fit: close the string now.
            push.valid       = 1'b1;
            push.job.has_nul = 1'b1;
            push.job.count   = written_r;
            closed_nxt       = 1'b1;
          end else begin
            space_after      = space_left_r - {13'd0, width};
            written_after    = written_r + {13'd0, width};
            push.valid       = 1'b1;
            push.job.data    = u2u8_pkg::utf8_bytes(value);
            push.job.nbytes  = width;
            space_left_nxt   = space_after;
            written_nxt      = written_after;
            if (space_after == 16'd0) begin
              push.job.has_nul = 1'b1;
              push.job.count   = written_after;
              closed_nxt       = 1'b1;
            end
          end
        end
      end
    end

    // A capacity write applies at once only between strings.
    if (cfg_valid && written_r == 16'd0 && !high_pending_r && !closed_r) begin
      space_left_nxt = (cfg_buffer_bytes == 16'd0) ? 16'd0 : cfg_buffer_bytes - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_pending_r <= 1'b0;
      high_bits_r    <= '0;
      space_left_r   <= u2u8_pkg::BufferBytesReset - 16'd1;
      written_r      <= '0;
      closed_r       <= 1'b0;
      buffer_bytes_r <= u2u8_pkg::BufferBytesReset;
    end else begin
      high_pending_r <= high_pending_nxt;
      high_bits_r    <= high_bits_nxt;
      space_left_r   <= space_left_nxt;
      written_r      <= written_nxt;
      closed_r       <= closed_nxt;
      if (cfg_valid) begin
        buffer_bytes_r <= cfg_buffer_bytes;
      end
    end
  end

endmodule

// ===== rtl/u2u8_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 converter job queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module u2u8_queue #(
  parameter int Depth = u2u8_pkg::QueueDepthDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  u2u8_pkg::u2u8_push_t push,
  output logic                 full,
  output u2u8_pkg::u2u8_head_t head,
  input  logic                 pop
);

  localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntWidth = $clog2(Depth + 1);
  localparam logic [CntWidth-1:0] DepthCnt = CntWidth'(Depth);
  localparam logic [PtrWidth-1:0] LastPtr  = PtrWidth'(Depth - 1);

  u2u8_pkg::u2u8_job_t slots_r [Depth];
  logic [PtrWidth-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrWidth-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntWidth-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign full       = (count_r == DepthCnt);
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && (count_r != '0);
  assign head.valid = (count_r != '0);
  assign head.job   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/u2u8_back.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 converter back end
// Sends the bytes of each job, then its terminator if it has one, through an output register.
// ----------------------------------------------------------------------------
module u2u8_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  u2u8_pkg::u2u8_head_t head,
  output logic                 pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic [7:0]           res_byte,
  output logic                 res_last,
  output logic [15:0]          res_count
);

  u2u8_pkg::u2u8_job_t         cur_r;
  logic                        cur_valid_r;
  logic [u2u8_pkg::NbWidth-1:0] idx_r;
  logic [u2u8_pkg::NbWidth-1:0] total;
  logic                        load;
  logic                        at_end;
  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  logic                        out_last_r;
  logic [15:0]                 out_count_r;

  assign total  = cur_r.nbytes + {2'd0, cur_r.has_nul};
  assign load   = cur_valid_r && (!out_valid_r || res_ready);
  assign at_end = (idx_r == total - 1'b1);
  assign pop    = head.valid && (!cur_valid_r || (load && at_end));

  assign res_valid = out_valid_r;
  assign res_byte  = out_byte_r;
  assign res_last  = out_last_r;
  assign res_count = out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (load) begin
        idx_r <= idx_r + 1'b1;
        if (at_end) begin
          cur_valid_r <= 1'b0;
        end
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head.job;
    end
    if (load) begin
      if (idx_r < cur_r.nbytes) begin
        out_byte_r  <= cur_r.data[idx_r[1:0]];
        out_last_r  <= 1'b0;
        out_count_r <= '0;
      end else begin
        out_byte_r  <= '0;
        out_last_r  <= 1'b1;
        out_count_r <= cur_r.count;
      end
    end
  end

endmodule

// ===== rtl/utf16_to_utf8_converter.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 converter
// Transcodes a stream of UTF-16 code units into UTF-8 bytes with a NUL end.
// ----------------------------------------------------------------------------
// The converter takes one UTF-16 code unit per input transaction and returns
// one UTF-8 byte per output transaction, lead byte first. A zero unit ends
// the string and yields a NUL byte with is_last set and the count of data
// bytes sent. The capacity register limits a string to buffer_bytes minus
// one data bytes; when a character does not fit, or the space is used up,
// the NUL goes out at once and later units are dropped until the zero unit.
// A high surrogate produces nothing until its low partner arrives. Timing:
// the input side takes a unit in every cycle while the job queue has room;
// the output side sends one byte per cycle while the receiver is ready, so
// a unit takes one output transaction for each byte it yields, zero to five
// (four data bytes plus a NUL). An accepted unit passes through the job
// queue, the back end's job register and the output register before its
// first byte goes out. Capacity writes are accepted in every cycle and
// should be made between strings; no clearing pass follows reset.
// ----------------------------------------------------------------------------
module utf16_to_utf8_converter #(
  parameter int QueueDepth = u2u8_pkg::QueueDepthDefault
) (
  input  logic          clk,
  input  logic          rst_n,
  u2u8_unit_if.sink     in_ch,
  u2u8_result_if.source out_ch,
  u2u8_cfg_if.sink      cfg_ch
);

  // Handshake between the front end, the queue and the back end.
  u2u8_pkg::u2u8_push_t push;
  u2u8_pkg::u2u8_head_t head;
  logic                 queue_full;
  logic                 pop;

  // The capacity register takes every write transaction immediately.
  assign cfg_ch.ready = 1'b1;

  // Front end: surrogate tracking, capacity bookkeeping and UTF-8 encoding
  // of each accepted unit into at most one job record, all in the accept cycle.
  u2u8_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .unit_valid       (in_ch.valid),
    .code_unit        (in_ch.code_unit),
    .unit_ready       (in_ch.ready),
    .cfg_valid        (cfg_ch.valid),
    .cfg_buffer_bytes (cfg_ch.buffer_bytes),
    .queue_full       (queue_full),
    .push             (push)
  );

  // Job queue: lets the front keep taking units while the back drains bytes.
  u2u8_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (queue_full),
    .head  (head),
    .pop   (pop)
  );

  // Back end: walks through each job byte by byte into the output register,
  // fetching the next job in the cycle its last byte is loaded.
  u2u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res_byte  (out_ch.out_byte),
    .res_last  (out_ch.is_last),
    .res_count (out_ch.bytes_written)
  );

endmodule

// ===== verif/utf16_to_utf8_converter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 converter testbench
// Streams code units into the converter through its valid/ready channels,
// predicts every UTF-8 byte and string terminator in a small tracker class,
// and compares each result byte field by field as it leaves the block.
// ----------------------------------------------------------------------------
module utf16_to_utf8_converter_test;

  // Generous bound on the whole run, in clock cycles.
  localparam int CycleLimit = 500000;
  // Idle cycles allowed after the last expected byte before a capacity write,
  // which covers units that produce nothing but may still be in flight.
  localparam int QuietCycles = 12;
  // Code units sent over the whole run before the random part stops.
  localparam int RandomTarget = 310;
  // Number of cycles the receiver refuses results during the pressure test.
  localparam int LongHold = 300;

  // One expected output transaction.
  typedef struct {
    logic [7:0]  octet;
    logic        last;
    logic [15:0] count;
  } utf8_result_t;

  // Tracks the converter's string state, turns each accepted code unit into
  // the bytes it must produce, and checks the bytes that come out.
  class utf8_byte_tracker;
    logic [15:0]  capacity;
    bit           high_waiting;
    logic [9:0]   high_payload;
    logic [15:0]  room_left;
    logic [15:0]  sent_count;
    bit           closed;
    utf8_result_t due_bytes[$];
    int unsigned  errors;

    function new();
      capacity = u2u8_pkg::BufferBytesReset;
      errors   = 0;
      restart();
    endfunction

    function logic [15:0] full_room();
      return (capacity == 16'd0) ? 16'd0 : capacity - 16'd1;
    endfunction

    function void restart();
      high_waiting = 1'b0;
      high_payload = '0;
      room_left    = full_room();
      sent_count   = '0;
      closed       = 1'b0;
    endfunction

    function void push_result(input logic [7:0] octet, input logic last,
                              input logic [15:0] count);
      utf8_result_t r;
      r.octet = octet;
      r.last  = last;
      r.count = count;
      due_bytes.push_back(r);
    endfunction

    function void close_out();
      push_result(8'h00, 1'b1, sent_count);
      closed       = 1'b1;
      high_waiting = 1'b0;
      high_payload = '0;
    endfunction

    // A new capacity applies at once only between strings.
    function void note_capacity(input logic [15:0] value);
      capacity = value;
      if (sent_count == 16'd0 && !high_waiting && !closed) room_left = full_room();
    endfunction

    // Returns 1 when the unit arrived while the string was already closed.
    function bit accept_unit(input logic [15:0] unit);
      logic [20:0] scalar;
      logic [7:0]  seq [4];
      int          nbytes;
      bit          was_closed;
      was_closed = closed;
      if (unit == 16'h0000) begin
        if (!closed) push_result(8'h00, 1'b1, sent_count);
        restart();
        return was_closed;
      end
      if (closed) return 1'b1;

      if (high_waiting) begin
        high_waiting = 1'b0;
        if (unit < u2u8_pkg::LowFirst || unit > u2u8_pkg::LowLast) begin
          high_payload = '0;
          return 1'b0;
        end
        scalar       = {1'b0, high_payload, unit[9:0]} + u2u8_pkg::SuppBase;
        high_payload = '0;
      end else begin
        if (room_left == 16'd0) begin
          close_out();
          return 1'b0;
        end
        if ((unit & u2u8_pkg::SurrMask) == u2u8_pkg::SurrFirst) begin
          if (unit <= u2u8_pkg::HighLast) begin
            high_waiting = 1'b1;
            high_payload = unit[9:0];
          end
          return 1'b0;
        end
        scalar = {5'b0, unit};
      end

      if (scalar < u2u8_pkg::TwoByteFirst) begin
        nbytes = 1;
        seq[0] = scalar[7:0];
      end else if (scalar < u2u8_pkg::ThreeByteFirst) begin
        nbytes = 2;
        seq[0] = 8'hC0 | scalar[10:6];
        seq[1] = 8'h80 | scalar[5:0];
      end else if (scalar < u2u8_pkg::FourByteFirst) begin
        nbytes = 3;
        seq[0] = 8'hE0 | scalar[15:12];
        seq[1] = 8'h80 | scalar[11:6];
        seq[2] = 8'h80 | scalar[5:0];
      end else begin
        nbytes = 4;
        seq[0] = 8'hF0 | scalar[20:18];
        seq[1] = 8'h80 | scalar[17:12];
        seq[2] = 8'h80 | scalar[11:6];
        seq[3] = 8'h80 | scalar[5:0];
      end

      if (room_left < nbytes) begin
        close_out();
        return 1'b0;
      end
      for (int i = 0; i < nbytes; i++) push_result(seq[i], 1'b0, 16'd0);
      room_left  = room_left - 16'(nbytes);
      sent_count = sent_count + 16'(nbytes);
      if (room_left == 16'd0) close_out();
      return 1'b0;
    endfunction

    function void check_result(input logic [7:0] octet, input logic last,
                               input logic [15:0] count);
      utf8_result_t want;
      if (due_bytes.size() == 0) begin
        $error("result with nothing outstanding: out_byte %02h is_last %0b bytes_written %0d",
               octet, last, count);
        errors++;
        return;
      end
      want = due_bytes.pop_front();
      if (want.octet !== octet) begin
        $error("out_byte: expected %02h, actual %02h", want.octet, octet);
        errors++;
      end
      if (want.last !== last) begin
        $error("is_last: expected %0b, actual %0b", want.last, last);
        errors++;
      end
      if (want.count !== count) begin
        $error("bytes_written: expected %0d, actual %0d", want.count, count);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  u2u8_unit_if   unit_bus ();
  u2u8_result_if byte_bus ();
  u2u8_cfg_if    cap_bus ();

  utf16_to_utf8_converter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (unit_bus),
    .out_ch (byte_bus),
    .cfg_ch (cap_bus)
  );

  utf8_byte_tracker byte_tracker = new();

  // Random idling on each side can be switched off for the final stretch.
  bit sender_gaps   = 1'b0;
  bit receiver_gaps = 1'b0;
  // Cycles the receiver still has to hold off; the main flow loads it only
  // right after a rising edge, the receiver counts it down on falling edges.
  int hold_cycles   = 0;
  // Code units accepted by the block so far.
  int sent_units    = 0;

  // Every input of the block gets a defined value at time zero.
  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    unit_bus.valid       = 1'b0;
    unit_bus.code_unit   = 16'h0000;
    cap_bus.valid        = 1'b0;
    cap_bus.buffer_bytes = 16'h0000;
    byte_bus.ready       = 1'b0;
  end

  initial begin
    #4;
    forever #4 clk = ~clk;
  end

  // Synchronous reset, released on a falling edge and never asserted again.
  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Result receiver. Ready changes on falling edges only. A long hold set by
  // the main flow takes precedence over the short random bursts.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        byte_bus.ready <= 1'b0;
        hold_cycles--;
      end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
        byte_bus.ready <= 1'b0;
        hold_cycles = $urandom_range(1, 10) - 1;
      end else begin
        byte_bus.ready <= 1'b1;
      end
    end
  end

  // Every accepted result transaction is checked against the oldest
  // outstanding prediction. Sampling happens at the rising edge, before the
  // block's own registers update.
  always @(posedge clk) begin
    if (rst_n && byte_bus.valid && byte_bus.ready) begin
      byte_tracker.check_result(byte_bus.out_byte, byte_bus.is_last, byte_bus.bytes_written);
    end
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // Offers one code unit, with an optional random gap first, and waits for
  // the transaction. Valid stays high afterwards so back-to-back units follow
  // without a gap; drain_and_pause lowers it when a phase ends.
  task automatic send_unit(input logic [15:0] unit);
    int gap;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      unit_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    unit_bus.valid     <= 1'b1;
    unit_bus.code_unit <= unit;
    do @(posedge clk); while (!unit_bus.ready);
    void'(byte_tracker.accept_unit(unit));
    sent_units++;
  endtask

  // Stops offering units, waits for every predicted byte, then lets the
  // block settle so units with no output are surely finished too.
  task automatic drain_and_pause();
    @(negedge clk);
    unit_bus.valid <= 1'b0;
    while (byte_tracker.due_bytes.size() != 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
  endtask

  // Writes the capacity register; only called while the block is idle.
  task automatic write_capacity(input logic [15:0] value);
    @(negedge clk);
    cap_bus.valid        <= 1'b1;
    cap_bus.buffer_bytes <= value;
    do @(posedge clk); while (!cap_bus.ready);
    byte_tracker.note_capacity(value);
    @(negedge clk);
    cap_bus.valid <= 1'b0;
  endtask

  // One character of random content. Most are well formed across all four
  // UTF-8 widths; the rest are lone lows, broken pairs and raw noise.
  task automatic send_char();
    int          pick;
    logic [15:0] unit;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_unit(16'($urandom_range(16'h0001, 16'h007F)));
    end else if (pick < 45) begin
      send_unit(16'($urandom_range(16'h0080, 16'h07FF)));
    end else if (pick < 65) begin
      // Three-byte range with the surrogate block skipped.
      unit = 16'($urandom_range(16'h0800, 16'hF7FF));
      if (unit >= u2u8_pkg::SurrFirst) unit = unit + 16'h0800;
      send_unit(unit);
    end else if (pick < 85) begin
      send_unit(16'($urandom_range(u2u8_pkg::SurrFirst, u2u8_pkg::HighLast)));
      send_unit(16'($urandom_range(u2u8_pkg::LowFirst, u2u8_pkg::LowLast)));
    end else if (pick < 90) begin
      send_unit(16'($urandom_range(u2u8_pkg::LowFirst, u2u8_pkg::LowLast)));
    end else if (pick < 95) begin
      send_unit(16'($urandom_range(u2u8_pkg::SurrFirst, u2u8_pkg::HighLast)));
      send_unit(16'($urandom_range(16'h0001, 16'hDBFF)));
    end else begin
      send_unit(16'($urandom_range(0, 16'hFFFF)));
    end
  endtask

  task automatic send_string(input int chars);
    repeat (chars) send_char();
    send_unit(16'h0000);
  endtask

  // Mostly small capacities so strings close early, with the register's
  // extremes and a fully random value mixed in.
  function automatic logic [15:0] pick_capacity();
    logic [15:0] value;
    case ($urandom_range(0, 11))
      0:       value = 16'd0;
      1:       value = 16'd1;
      2:       value = 16'd2;
      3:       value = 16'd3;
      4:       value = 16'd4;
      5:       value = 16'd5;
      6:       value = 16'd7;
      7:       value = 16'd12;
      8:       value = 16'd30;
      9:       value = 16'd65535;
      10:      value = 16'($urandom_range(1, 16'hFFFF));
      default: value = u2u8_pkg::BufferBytesReset;
    endcase
    return value;
  endfunction

  initial begin
    @(posedge rst_n);
    @(posedge clk);

    // Directed part at the reset capacity: the edges of each UTF-8 width,
    // the smallest and largest surrogate pairs, a lone low surrogate, a high
    // surrogate broken by a plain character, and a high surrogate cut short
    // by the terminator. That string carries twenty data bytes.
    send_unit(16'h0041);
    send_unit(16'h007F);
    send_unit(16'h0080);
    send_unit(16'h07FF);
    send_unit(16'h0800);
    send_unit(16'hFFFF);
    send_unit(16'hD800);
    send_unit(16'hDC00);
    send_unit(16'hDBFF);
    send_unit(16'hDFFF);
    send_unit(16'hDC00);
    send_unit(16'hD800);
    send_unit(16'h0041);
    send_unit(16'hD834);
    send_unit(16'h0000);
    // An empty string still yields its terminator with a zero count.
    send_unit(16'h0000);

    // A capacity write in the middle of a string waits for the next string.
    send_unit(16'h0041);
    drain_and_pause();
    write_capacity(16'd3);
    send_unit(16'h0000);
    // Now two data bytes fit: a two-byte character fills them exactly and
    // the terminator follows at once; the zero unit then rearms silently.
    send_unit(16'h00E9);
    send_unit(16'h0000);
    // A three-byte character does not fit, so only the terminator comes out.
    send_unit(16'h0800);
    send_unit(16'h0000);
    drain_and_pause();

    // No room for data at all: the first character turns into the terminator.
    write_capacity(16'd1);
    send_unit(16'h0041);
    send_unit(16'h0000);
    drain_and_pause();
    // A zero capacity behaves like a capacity of one.
    write_capacity(16'd0);
    send_unit(16'h0042);
    send_unit(16'h0000);
    drain_and_pause();

    // Backpressure: the receiver holds off for a long stretch while a long
    // string keeps coming, so the internal queue fills and input ready drops.
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    write_capacity(u2u8_pkg::BufferBytesReset);
    @(posedge clk);
    hold_cycles = LongHold;
    send_string(40);
    drain_and_pause();

    // Random phases: a capacity, then a few strings. Some phases begin with
    // a half-finished string so the write lands while that string is open.
    // The last stretch runs with no idling on either side.
    while (sent_units < RandomTarget) begin
      if (sent_units > RandomTarget - 60) begin
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) send_char();
        drain_and_pause();
      end
      write_capacity(pick_capacity());
      repeat ($urandom_range(1, 4)) send_string($urandom_range(0, 12));
      drain_and_pause();
    end

    // drain_and_pause has already waited for every byte and a quiet spell;
    // a few more cycles catch any stray result.
    repeat (20) @(posedge clk);
    if (byte_tracker.due_bytes.size() != 0) begin
      $error("%0d predicted results never arrived", byte_tracker.due_bytes.size());
      byte_tracker.errors++;
    end
    if (byte_tracker.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
